// File: sv/tccw_pkg.sv
// tccw_pkg: shared types, constants and codes for the text console character writer
// no dependencies; used by tccw_ram users and text_console_character_writer

package tccw_pkg;

  // screen geometry
  localparam int COLS      = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = ROWS * COLS;

  // internal widths
  localparam int COL_W  = $clog2(COLS);
  localparam int COLN_W = $clog2(COLS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  // port field widths
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int COL_IN_W = 7;
  localparam int ROW_IN_W = 5;
  localparam int SBYTE_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SET   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

  // control characters
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_ECHO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CHAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR  = 2'd2;

  // reset values
  localparam logic [CHAR_W-1:0] RESET_BLANK_CHAR = 8'd32;
  localparam logic [CHAR_W-1:0] RESET_BLANK_ATTR = 8'd7;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BLANK_ATTR, RESET_BLANK_CHAR};

  // tab stop marks, one per column position including the row end
  function automatic logic [COLS:0] tab_stops();
    logic [COLS:0] m;
    for (int i = 0; i <= COLS; i++) begin
      m[i] = ((i % TAB_WIDTH) == 0) || (i == COLS);
    end
    return m;
  endfunction

  localparam logic [COLS:0] TAB_STOP = tab_stops();

  // sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_CLEAR,
    S_RDATA,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  fg_color;
    logic [COLOR_W-1:0]  bg_color;
    logic [COL_IN_W-1:0] col;
    logic [ROW_IN_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [COL_IN_W-1:0] cursor_col;
    logic [ROW_IN_W-1:0] cursor_row;
    logic [CHAR_W-1:0]   cell_char;
    logic [CHAR_W-1:0]   cell_attr;
    logic                serial_valid;
    logic [SBYTE_W-1:0]  serial_byte;
  } out_item_t;

endpackage

// File: sv/tccw_ram.sv
// tccw_ram: generic single port synchronous RAM with registered read
// no dependencies

module tccw_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/text_console_character_writer.sv
// text_console_character_writer: character screen store with cursor, scroll and clear
// depends on tccw_pkg and tccw_ram
//
// Usage: one item in, one result out. An input transfer happens when in_valid_i is high
// and in_stall_o is low; an output transfer when out_valid_o is high and out_stall_i low.
// The screen lives in one RAM of ROWS*COLS cells; scrolling moves a top-row pointer
// instead of copying, so only the new bottom row is rewritten.
// The RAM has one port and a fill writes one cell per cycle. Cursor move and CR do not
// touch the RAM; read_cell reads one cell; put_char writes one; clear rewrites all
// ROWS*COLS cells (2000); TAB blanks up to the next tab stop (at most TAB_WIDTH cells)
// and LF to the row end; a wrap on the bottom row also rewrites the COLS-cell scroll-in row.
// The result sits in an output register; a new item is taken while it still waits,
// and a finished item holds in the done state until that register is free.
// After reset all ROWS*COLS cells are swept to blank (char 32, attribute 7) with in_stall_o
// high; configuration writes are taken throughout. Configuration writes take effect at once;
// the user must make them only while the block is idle; the block does not enforce this.

module text_console_character_writer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tccw_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tccw_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tccw_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  tccw_pkg::state_e state_q, state_d;

  logic [tccw_pkg::COL_W-1:0]  x_q, x_d;
  logic [tccw_pkg::ROW_W-1:0]  y_q, y_d;
  logic [tccw_pkg::ROW_W-1:0]  top_q, top_d;
  logic [tccw_pkg::ADDR_W-1:0] sweep_q, sweep_d;
  logic                        tab_q, tab_d;
  logic                        scroll_q, scroll_d;
  logic [tccw_pkg::CELL_W-1:0] fill_q, fill_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;

  // configuration registers
  logic                        echo_en_q;
  logic [tccw_pkg::CHAR_W-1:0] blank_char_q;
  logic [tccw_pkg::CHAR_W-1:0] blank_attr_q;

  // accepted item, coordinates already saturated
  logic [tccw_pkg::ACTION_W-1:0] op_q;
  logic [tccw_pkg::CHAR_W-1:0]   code_q;
  logic [tccw_pkg::CHAR_W-1:0]   attr_q;
  logic [tccw_pkg::COL_W-1:0]    icol_q;
  logic [tccw_pkg::ROW_W-1:0]    irow_q;
  logic [tccw_pkg::CHAR_W-1:0]   rd_char_q;
  logic [tccw_pkg::CHAR_W-1:0]   rd_attr_q;
  logic                          echo_v_q;
  logic [tccw_pkg::SBYTE_W-1:0]  echo_b_q;
  tccw_pkg::out_item_t           out_q;

  logic                          in_xfer;
  logic [tccw_pkg::COL_W-1:0]    col_sat;
  logic [tccw_pkg::ROW_W-1:0]    row_sat;

  // ram access
  logic                          ram_we;
  logic [tccw_pkg::ADDR_W-1:0]   ram_addr;
  logic [tccw_pkg::CELL_W-1:0]   ram_wdata;
  logic [tccw_pkg::CELL_W-1:0]   ram_rdata;
  logic                          use_item_pos;
  logic [tccw_pkg::ROW_W-1:0]    row_sel;
  logic [tccw_pkg::COL_W-1:0]    col_sel;
  logic [tccw_pkg::ROW_W:0]      row_sum;
  logic [tccw_pkg::ROW_W-1:0]    phys_row;
  logic [tccw_pkg::ADDR_W-1:0]   cell_addr;

  logic [tccw_pkg::COLN_W-1:0]   x_inc;
  logic                          do_wrap;
  logic                          sweep_last;

  assign in_stall_o  = (state_q != tccw_pkg::S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // coordinate saturation on the incoming item
  assign col_sat = (int'(in_data_i.col) > tccw_pkg::COLS - 1) ?
                   tccw_pkg::COL_W'(tccw_pkg::COLS - 1) :
                   tccw_pkg::COL_W'(in_data_i.col);
  assign row_sat = (int'(in_data_i.row) > tccw_pkg::ROWS - 1) ?
                   tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1) :
                   tccw_pkg::ROW_W'(in_data_i.row);

  // logical row to ram address through the rotating top row
  assign row_sel  = use_item_pos ? irow_q : y_q;
  assign col_sel  = use_item_pos ? icol_q : x_q;
  assign row_sum  = {1'b0, row_sel} + {1'b0, top_q};
  assign phys_row = (row_sum >= (tccw_pkg::ROW_W + 1)'(tccw_pkg::ROWS)) ?
                    tccw_pkg::ROW_W'(row_sum - (tccw_pkg::ROW_W + 1)'(tccw_pkg::ROWS)) :
                    tccw_pkg::ROW_W'(row_sum);
  assign cell_addr = tccw_pkg::ADDR_W'(phys_row) * tccw_pkg::ADDR_W'(tccw_pkg::COLS) +
                     tccw_pkg::ADDR_W'(col_sel);

  assign x_inc      = tccw_pkg::COLN_W'(x_q) + tccw_pkg::COLN_W'(1);
  assign sweep_last = (sweep_q == tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1));

  tccw_ram #(
    .WIDTH (tccw_pkg::CELL_W),
    .DEPTH (tccw_pkg::CELLS)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // sequencer: next state, cursor and ram controls
  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    y_d          = y_q;
    top_d        = top_q;
    sweep_d      = sweep_q;
    tab_d        = tab_q;
    scroll_d     = scroll_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = cell_addr;
    ram_wdata    = fill_q;
    use_item_pos = 1'b0;
    do_wrap      = 1'b0;

    // output register drains on transfer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tccw_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_q;
        ram_wdata = tccw_pkg::RESET_CELL;
        if (sweep_last) begin
          sweep_d = '0;
          state_d = tccw_pkg::S_IDLE;
        end else begin
          sweep_d = sweep_q + tccw_pkg::ADDR_W'(1);
        end
      end
      tccw_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_d = tccw_pkg::S_EXEC;
        end
      end
      tccw_pkg::S_EXEC: begin
        unique case (op_q)
          tccw_pkg::ACT_PUT: begin
            if (code_q == tccw_pkg::CHAR_CR) begin
              x_d     = '0;
              state_d = tccw_pkg::S_DONE;
            end else if (code_q == tccw_pkg::CHAR_LF || code_q == tccw_pkg::CHAR_TAB) begin
              tab_d    = (code_q == tccw_pkg::CHAR_TAB);
              scroll_d = 1'b0;
              fill_d   = {attr_q, blank_char_q};
              state_d  = tccw_pkg::S_FILL;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {attr_q, code_q};
              if (x_inc == tccw_pkg::COLN_W'(tccw_pkg::COLS)) begin
                do_wrap = 1'b1;
              end else begin
                x_d     = tccw_pkg::COL_W'(x_inc);
                state_d = tccw_pkg::S_DONE;
              end
            end
          end
          tccw_pkg::ACT_READ: begin
            use_item_pos = 1'b1;
            state_d      = tccw_pkg::S_RDATA;
          end
          tccw_pkg::ACT_SET: begin
            x_d     = icol_q;
            y_d     = irow_q;
            state_d = tccw_pkg::S_DONE;
          end
          tccw_pkg::ACT_CLEAR: begin
            x_d     = '0;
            y_d     = '0;
            top_d   = '0;
            sweep_d = '0;
            fill_d  = {blank_attr_q, blank_char_q};
            state_d = tccw_pkg::S_CLEAR;
          end
          default: begin
            state_d = tccw_pkg::S_DONE;
          end
        endcase
      end
      tccw_pkg::S_FILL: begin
        ram_we = 1'b1;
        if (x_inc == tccw_pkg::COLN_W'(tccw_pkg::COLS) ||
            (tab_q && tccw_pkg::TAB_STOP[x_inc])) begin
          if (scroll_q) begin
            x_d      = '0;
            scroll_d = 1'b0;
            state_d  = tccw_pkg::S_DONE;
          end else if (x_inc == tccw_pkg::COLN_W'(tccw_pkg::COLS)) begin
            do_wrap = 1'b1;
          end else begin
            x_d     = tccw_pkg::COL_W'(x_inc);
            state_d = tccw_pkg::S_DONE;
          end
        end else begin
          x_d = tccw_pkg::COL_W'(x_inc);
        end
      end
      tccw_pkg::S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = sweep_q;
        if (sweep_last) begin
          sweep_d = '0;
          state_d = tccw_pkg::S_DONE;
        end else begin
          sweep_d = sweep_q + tccw_pkg::ADDR_W'(1);
        end
      end
      tccw_pkg::S_RDATA: begin
        state_d = tccw_pkg::S_DONE;
      end
      tccw_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = tccw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tccw_pkg::S_IDLE;
      end
    endcase

    // cursor wrap: next row, or scroll by moving the top row and blanking the new bottom
    if (do_wrap) begin
      x_d = '0;
      if (int'(y_q) < tccw_pkg::ROWS - 1) begin
        y_d     = y_q + tccw_pkg::ROW_W'(1);
        state_d = tccw_pkg::S_DONE;
      end else begin
        top_d    = (int'(top_q) == tccw_pkg::ROWS - 1) ? '0 : top_q + tccw_pkg::ROW_W'(1);
        scroll_d = 1'b1;
        tab_d    = 1'b0;
        fill_d   = {blank_attr_q, blank_char_q};
        state_d  = tccw_pkg::S_FILL;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccw_pkg::S_INIT;
      x_q         <= '0;
      y_q         <= '0;
      top_q       <= '0;
      sweep_q     <= '0;
      tab_q       <= 1'b0;
      scroll_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      top_q       <= top_d;
      sweep_q     <= sweep_d;
      tab_q       <= tab_d;
      scroll_q    <= scroll_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_en_q    <= 1'b0;
      blank_char_q <= tccw_pkg::RESET_BLANK_CHAR;
      blank_attr_q <= tccw_pkg::RESET_BLANK_ATTR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tccw_pkg::CFG_SERIAL_ECHO: echo_en_q    <= cfg_data_i[0];
        tccw_pkg::CFG_BLANK_CHAR:  blank_char_q <= cfg_data_i;
        tccw_pkg::CFG_BLANK_ATTR:  blank_attr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    if (in_xfer) begin
      op_q      <= in_data_i.action;
      code_q    <= in_data_i.char_code;
      attr_q    <= {in_data_i.bg_color, in_data_i.fg_color};
      icol_q    <= col_sat;
      irow_q    <= row_sat;
      rd_char_q <= '0;
      rd_attr_q <= '0;
      echo_v_q  <= (in_data_i.action == tccw_pkg::ACT_PUT) && echo_en_q;
      echo_b_q  <= ((in_data_i.action == tccw_pkg::ACT_PUT) && echo_en_q) ?
                   in_data_i.char_code[tccw_pkg::SBYTE_W-1:0] : '0;
    end
    if (state_q == tccw_pkg::S_RDATA) begin
      rd_char_q <= ram_rdata[tccw_pkg::CHAR_W-1:0];
      rd_attr_q <= ram_rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
    end
    if (out_load) begin
      out_q.cursor_col   <= tccw_pkg::COL_IN_W'(x_q);
      out_q.cursor_row   <= tccw_pkg::ROW_IN_W'(y_q);
      out_q.cell_char    <= rd_char_q;
      out_q.cell_attr    <= rd_attr_q;
      out_q.serial_valid <= echo_v_q;
      out_q.serial_byte  <= echo_b_q;
    end
  end

`ifndef SYNTHESIS
  // items enter only when the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == tccw_pkg::S_EXEC)
    else $error("item taken outside idle");

  // cursor and top row stay on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(x_q) < tccw_pkg::COLS) && (int'(y_q) < tccw_pkg::ROWS) &&
    (int'(top_q) < tccw_pkg::ROWS))
    else $error("cursor or top row off screen");

  // ram writes stay inside the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> int'(ram_addr) < tccw_pkg::CELLS)
    else $error("ram write out of range");

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result overwritten while stalled");

  // scroll-in fill only runs on the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccw_pkg::S_FILL && scroll_q) |-> int'(y_q) == tccw_pkg::ROWS - 1)
    else $error("scroll fill away from bottom row");
`endif

endmodule
